@@ rtl/efr_pkg.sv @@
// ----------------------------------------------------------------------------
// efr_pkg: shared types and constants of the Ethernet frame reflector
// Header offsets, delay line shape and the structs passed between modules.
// ----------------------------------------------------------------------------
package efr_pkg;

  // byte position within a frame, saturating
  localparam int POS_W = 7;
  localparam logic [POS_W-1:0] POS_MAX = 7'd127;

  // delay line: six bytes held plus the newest one
  localparam int WIN_DEPTH = 7;
  localparam logic [2:0] DELAY_LEN = 3'd6;

  // Ethernet header layout
  localparam logic [POS_W-1:0] MAC_LEN      = 7'd6;
  localparam logic [POS_W-1:0] MAC_PAIR_END = 7'd12;
  localparam logic [POS_W-1:0] ETYPE_HI_POS = 7'd12;
  localparam logic [POS_W-1:0] ETYPE_LO_POS = 7'd13;
  localparam logic [POS_W-1:0] INNER_HI_POS = 7'd16;
  localparam logic [POS_W-1:0] INNER_LO_POS = 7'd17;
  localparam logic [POS_W-1:0] L3_PLAIN     = 7'd14;
  localparam logic [POS_W-1:0] L3_TAGGED    = 7'd18;

  // IPv4 header layout, relative to the start of the IPv4 header
  localparam logic [POS_W-1:0] IP_PROTO_OFS = 7'd9;
  localparam logic [POS_W-1:0] IP_SRC_OFS   = 7'd12;
  localparam logic [POS_W-1:0] IP_DST_OFS   = 7'd16;
  localparam logic [POS_W-1:0] IP_END_OFS   = 7'd20;
  localparam logic [POS_W-1:0] IP_ADDR_LEN  = 7'd4;
  localparam logic [POS_W-1:0] UDP_PORT_LEN = 7'd2;

  localparam logic [15:0] TYPE_IPV4  = 16'h0800;
  localparam logic [15:0] TPID_RESET = 16'h8100;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [7:0]  IHL_MASK   = 8'h0f;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_VLAN_TPID = 1'b0;

  typedef logic [7:0] byte_t;

  // index 0 holds the newest byte, index k the byte received k bytes earlier
  typedef logic [WIN_DEPTH-1:0][7:0] efr_window_t;

  typedef struct packed {
    logic       vlan_tag;
    logic       ipv4;
    logic       udp;
    logic [3:0] header_words;
  } efr_hdr_t;

  typedef struct packed {
    logic [5:0][7:0] dst_mac;
    logic [3:0][7:0] src_ip;
    logic [1:0][7:0] udp_sport;
  } efr_saved_t;

  typedef struct packed {
    byte_t data;
    logic  last;
  } efr_out_t;

endpackage

@@ rtl/efr_cfg.sv @@
// ----------------------------------------------------------------------------
// efr_cfg: configuration register file
// APB-style port holding the VLAN TPID register.
// ----------------------------------------------------------------------------
module efr_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [efr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [15:0]                    vlan_tpid
);
  import efr_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // write the TPID register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      vlan_tpid <= TPID_RESET;
    end else if (wr_en && paddr[2] == REG_VLAN_TPID) begin
      vlan_tpid <= pwdata[15:0];
    end
  end

  // return the addressed register, zero beyond the list
  always_comb begin
    if (paddr[2] == REG_VLAN_TPID) begin
      prdata = {16'd0, vlan_tpid};
    end else begin
      prdata = '0;
    end
  end

endmodule

@@ rtl/efr_parser.sv @@
// ----------------------------------------------------------------------------
// efr_parser: header parser and delay line
// Tracks the byte position, decodes the VLAN, IPv4 and UDP headers, saves the
// partner bytes that leave too early for the swap and shifts the delay line.
// ----------------------------------------------------------------------------
module efr_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [7:0]                data_byte,
  input  logic                      last,
  input  logic                      frame_clear,
  input  logic [15:0]               vlan_tpid,
  output logic [efr_pkg::POS_W-1:0] byte_position,
  output efr_pkg::efr_hdr_t         hdr,
  output efr_pkg::efr_window_t      window,
  output efr_pkg::efr_saved_t       saved
);
  import efr_pkg::*;

  logic [15:0]      type_field;
  logic [15:0]      type_field_next;
  logic [15:0]      type_low;
  efr_hdr_t         hdr_next;
  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] l3;
  logic [POS_W-1:0] u;
  logic [POS_W-1:0] ip_ofs;
  logic [POS_W-1:0] port_ofs;
  logic [3:0]       hw_eff;
  logic             ip_wr;
  logic             port_wr;
  logic             mac_wr;

  // decode the current byte against the header layout
  always_comb begin
    type_field_next = type_field;
    hdr_next        = hdr;
    type_low        = {type_field[15:8], data_byte};
    l3              = hdr.vlan_tag ? L3_TAGGED : L3_PLAIN;
    hw_eff          = hdr.header_words;
    if (hdr.ipv4 && byte_position == l3) begin
      hw_eff = 4'(data_byte & IHL_MASK);
    end
    u        = l3 + {1'b0, hw_eff, 2'b00};
    ip_ofs   = byte_position - l3 - IP_SRC_OFS;
    port_ofs = byte_position - u;

    // outer ethertype
    if (byte_position == ETYPE_HI_POS) begin
      type_field_next = {data_byte, 8'h00};
    end
    if (byte_position == ETYPE_LO_POS) begin
      type_field_next = type_low;
      if (type_low == vlan_tpid) begin
        hdr_next.vlan_tag = 1'b1;
      end else if (type_low == TYPE_IPV4) begin
        hdr_next.ipv4 = 1'b1;
      end
    end

    // inner ethertype behind the tag
    if (hdr.vlan_tag && byte_position == INNER_HI_POS) begin
      type_field_next = {data_byte, 8'h00};
    end
    if (hdr.vlan_tag && byte_position == INNER_LO_POS) begin
      type_field_next = type_low;
      if (type_low == TYPE_IPV4) begin
        hdr_next.ipv4 = 1'b1;
      end
    end

    // IPv4 header length and protocol
    if (hdr.ipv4) begin
      hdr_next.header_words = hw_eff;
      if (byte_position == l3 + IP_PROTO_OFS) begin
        hdr_next.udp = (data_byte == PROTO_UDP);
      end
    end

    mac_wr  = byte_position < MAC_LEN;
    ip_wr   = hdr.ipv4 && byte_position >= l3 + IP_SRC_OFS
              && byte_position < l3 + IP_DST_OFS;
    port_wr = hdr.ipv4 && (byte_position == u || byte_position == u + 7'd1);

    // advance the position unless this is the last byte or the position is at POS_MAX
    if (last || byte_position == POS_MAX) begin
      pos_next = byte_position;
    end else begin
      pos_next = byte_position + 7'd1;
    end
  end

  // per-frame control state: update on accept, drop at the end of the flush
  always_ff @(posedge clk) begin
    if (rst || frame_clear) begin
      byte_position <= '0;
      type_field    <= '0;
      hdr           <= '0;
      window        <= '0;
    end else if (accept) begin
      byte_position <= pos_next;
      type_field    <= type_field_next;
      hdr           <= hdr_next;
      window        <= {window[WIN_DEPTH-2:0], data_byte};
    end
  end

  // hold the partner bytes; written before they are read in the same frame
  always_ff @(posedge clk) begin
    if (accept && mac_wr) begin
      saved.dst_mac[byte_position[2:0]] <= data_byte;
    end
    if (accept && ip_wr) begin
      saved.src_ip[ip_ofs[1:0]] <= data_byte;
    end
    if (accept && port_wr) begin
      saved.udp_sport[port_ofs[0]] <= data_byte;
    end
  end

endmodule

@@ rtl/efr_select.sv @@
// ----------------------------------------------------------------------------
// efr_select: output byte selection
// Maps an output position to the received position whose byte goes there and
// picks that byte from the delay line or from the saved partner bytes.
// ----------------------------------------------------------------------------
module efr_select (
  input  logic [efr_pkg::POS_W-1:0] q,
  input  logic [2:0]                age_q,
  input  efr_pkg::efr_hdr_t         hdr,
  input  efr_pkg::efr_window_t      window,
  input  efr_pkg::efr_saved_t       saved,
  output logic [7:0]                out_byte
);
  import efr_pkg::*;

  logic [POS_W-1:0] l3;
  logic [POS_W-1:0] u;
  logic [POS_W-1:0] s_port;
  logic [POS_W-1:0] s_ip;
  logic [POS_W-1:0] src;
  logic [POS_W-1:0] src_f;
  logic [POS_W-1:0] ip_ofs;
  logic [POS_W-1:0] port_ofs;
  logic [7:0]       age_w;
  logic [3:0]       age_f;
  logic             port_on;

  always_comb begin
    l3      = hdr.vlan_tag ? L3_TAGGED : L3_PLAIN;
    u       = l3 + {1'b0, hdr.header_words, 2'b00};
    port_on = hdr.ipv4 && hdr.udp && (hdr.header_words != 4'd0);

    // swap the UDP ports first
    s_port = q;
    if (port_on && q >= u && q < u + UDP_PORT_LEN) begin
      s_port = q + UDP_PORT_LEN;
    end else if (port_on && q >= u + UDP_PORT_LEN
                 && q < u + UDP_PORT_LEN + UDP_PORT_LEN) begin
      s_port = q - UDP_PORT_LEN;
    end

    // then the IPv4 addresses
    s_ip = s_port;
    if (hdr.ipv4 && s_port >= l3 + IP_SRC_OFS && s_port < l3 + IP_DST_OFS) begin
      s_ip = s_port + IP_ADDR_LEN;
    end else if (hdr.ipv4 && s_port >= l3 + IP_DST_OFS && s_port < l3 + IP_END_OFS) begin
      s_ip = s_port - IP_ADDR_LEN;
    end

    // MAC addresses always swap
    if (q < MAC_LEN) begin
      src = q + MAC_LEN;
    end else if (q < MAC_PAIR_END) begin
      src = q - MAC_LEN;
    end else begin
      src = s_ip;
    end

    // age of the source byte; a source not yet received leaves the byte as is
    age_w = {5'd0, age_q} + {1'b0, q} - {1'b0, src};
    if (age_w[7]) begin
      src_f = q;
      age_f = {1'b0, age_q};
    end else begin
      src_f = src;
      age_f = age_w[3:0];
    end

    ip_ofs   = src_f - l3 - IP_SRC_OFS;
    port_ofs = src_f - u;

    // pick from the delay line, else from the saved partner bytes
    if (age_f <= {1'b0, DELAY_LEN}) begin
      out_byte = window[age_f[2:0]];
    end else if (src_f < MAC_LEN) begin
      out_byte = saved.dst_mac[src_f[2:0]];
    end else if (src_f >= l3 + IP_SRC_OFS && src_f < l3 + IP_DST_OFS) begin
      out_byte = saved.src_ip[ip_ofs[1:0]];
    end else if (src_f == u || src_f == u + 7'd1) begin
      out_byte = saved.udp_sport[port_ofs[0]];
    end else begin
      out_byte = '0;
    end
  end

endmodule

@@ rtl/efr_out_buf.sv @@
// ----------------------------------------------------------------------------
// efr_out_buf: output register with skid entry
// Two-entry queue that decouples the result stage from output stalls.
// ----------------------------------------------------------------------------
module efr_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  efr_pkg::efr_out_t push_data,
  output logic              full,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [7:0] out_byte
  output logic              m_tlast    // out_last
);
  import efr_pkg::*;

  efr_out_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full     = (count == 2'd2);
  assign m_tvalid = (count != 2'd0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = entries[rd_ptr].data;
  assign m_tlast  = entries[rd_ptr].last;

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // store the result
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/ethernet_frame_reflector_top.sv @@
// ----------------------------------------------------------------------------
// ethernet_frame_reflector_top: Ethernet frame reflector
// Rewrites a byte stream with MAC, IPv4 address and UDP port swaps.
// ----------------------------------------------------------------------------
// Frames enter one byte per transaction on s_* and leave six bytes late on
// m_*, with the MAC addresses swapped, one VLAN tag (TPID from register 0 at
// address 0) kept in place, IPv4 addresses swapped and, for UDP, the ports
// swapped at IHL*4 bytes into the IPv4 header. Within a frame one byte is
// accepted every cycle unless the output stalls; each result is registered
// in the result stage and then in the output buffer. When the byte marked
// tlast is accepted, the input is held while the remaining min(N-1,6)+1
// bytes of an N-byte frame are flushed, one per cycle unless the output
// stalls, through the single result stage; the next frame starts once the
// last result leaves the result stage. No clearing pass follows reset.
module ethernet_frame_reflector_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] data_byte
  input  logic                           s_tlast,   // last
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [7:0] out_byte
  output logic                           m_tlast,   // out_last
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [efr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import efr_pkg::*;

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_FLUSH = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [2:0]       cnt;
  logic [2:0]       cnt_next;
  logic             pend_valid;
  logic             pend_valid_next;
  logic [POS_W-1:0] pend_q;
  logic [POS_W-1:0] pend_q_next;
  logic [2:0]       pend_age;
  logic [2:0]       pend_age_next;
  logic             pend_last;
  logic             pend_last_next;
  logic             pend_fire;
  logic             pend_free;
  logic             in_fire;
  logic             frame_clear;
  logic             buf_full;
  logic [15:0]      vlan_tpid;
  logic [POS_W-1:0] pos;
  efr_hdr_t         hdr;
  efr_window_t      window;
  efr_saved_t       saved;
  logic [7:0]       sel_byte;
  efr_out_t         push_data;

  efr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .vlan_tpid (vlan_tpid)
  );

  efr_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_fire),
    .data_byte     (s_tdata),
    .last          (s_tlast),
    .frame_clear   (frame_clear),
    .vlan_tpid     (vlan_tpid),
    .byte_position (pos),
    .hdr           (hdr),
    .window        (window),
    .saved         (saved)
  );

  efr_select u_select (
    .q        (pend_q),
    .age_q    (pend_age),
    .hdr      (hdr),
    .window   (window),
    .saved    (saved),
    .out_byte (sel_byte)
  );

  efr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (pend_fire),
    .push_data (push_data),
    .full      (buf_full),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  assign push_data   = '{data: sel_byte, last: pend_last};
  assign pend_fire   = pend_valid && !buf_full;
  assign pend_free   = !pend_valid || pend_fire;
  assign s_tready    = (state == ST_RUN) && pend_free;
  assign in_fire     = s_tvalid && s_tready;
  assign frame_clear = pend_fire && pend_last;

  // sequence the result stage: one result per byte from position DELAY_LEN on, then the flush
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    pend_valid_next = pend_valid && !pend_fire;
    pend_q_next     = pend_q;
    pend_age_next   = pend_age;
    pend_last_next  = pend_last && !pend_fire;
    case (state)
      ST_RUN: begin
        if (in_fire && s_tlast) begin
          state_next = ST_FLUSH;
          cnt_next   = (pos >= {4'd0, DELAY_LEN}) ? DELAY_LEN : pos[2:0];
        end else if (in_fire && pos >= {4'd0, DELAY_LEN}) begin
          pend_valid_next = 1'b1;
          pend_q_next     = pos - {4'd0, DELAY_LEN};
          pend_age_next   = DELAY_LEN;
          pend_last_next  = 1'b0;
        end
      end
      ST_FLUSH: begin
        if (pend_free) begin
          pend_valid_next = 1'b1;
          pend_q_next     = pos - {4'd0, cnt};
          pend_age_next   = cnt;
          pend_last_next  = (cnt == 3'd0);
          if (cnt == 3'd0) begin
            state_next = ST_DRAIN;
          end else begin
            cnt_next = cnt - 3'd1;
          end
        end
      end
      ST_DRAIN: begin
        if (frame_clear) begin
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      cnt        <= 3'd0;
      pend_valid <= 1'b0;
      pend_last  <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      pend_valid <= pend_valid_next;
      pend_last  <= pend_last_next;
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    pend_q   <= pend_q_next;
    pend_age <= pend_age_next;
  end

  // no input while a flush is running
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH || state == ST_DRAIN) |-> !s_tready)
    else $error("input accepted during flush");

  // the last byte of a frame starts the flush
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> (state == ST_FLUSH))
    else $error("flush not started after last byte");

  // a pending last result only exists while draining
  assert property (@(posedge clk) disable iff (rst)
    (pend_valid && pend_last) |-> (state == ST_DRAIN))
    else $error("last result outside drain");

  // delivering the last result returns the frame state to the start
  assert property (@(posedge clk) disable iff (rst)
    (pend_fire && pend_last) |=> (pos == '0 && hdr == '0))
    else $error("frame state not cleared after flush");

endmodule
